// ===== src/cch_pkg.sv =====
// shared types, constants and helpers for the calibrated compass heading block
`timescale 1ns / 1ps

package cch_pkg;

    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int OFFS_REG_W = 60;
    localparam int ROW_REG_W  = 48;
    localparam int DECL_W     = 16;
    localparam int ANGLE_W    = 26;
    localparam int TURN_W     = 27;
    localparam int ARC_LEN    = 24;
    localparam int ARC_W      = 21;
    localparam int HEADING_W  = 16;
    localparam int CARD_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ANGLE_SUB_LOG = 8;

    localparam logic [TURN_W-1:0]    FULL_TURN    = TURN_W'(9216000);
    localparam logic [ANGLE_W-1:0]   HALF_TURN    = ANGLE_W'(4608000);
    localparam logic [HEADING_W:0]   HEADING_WRAP = 17'(36000);

    localparam logic [ROW_REG_W-1:0] ROW_X_RESET = 48'h0000_0000_4000;
    localparam logic [ROW_REG_W-1:0] ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_REG_W-1:0] ROW_Z_RESET = 48'h4000_0000_0000;

    localparam logic [ARC_W-1:0] ARC_TABLE [ARC_LEN] = '{
        21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
        21'd22916, 21'd11459, 21'd5730, 21'd2865, 21'd1432, 21'd716,
        21'd358, 21'd179, 21'd90, 21'd45, 21'd22, 21'd11, 21'd6, 21'd3,
        21'd1, 21'd1, 21'd0, 21'd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HARD_IRON   = 3'd0,
        CFG_ROW_X       = 3'd1,
        CFG_ROW_Y       = 3'd2,
        CFG_ROW_Z       = 3'd3,
        CFG_DECLINATION = 3'd4
    } cfg_reg_t;

    // eight 45 degree sectors centered on north, east and so on
    function automatic logic [CARD_W-1:0] sector_of(input logic [HEADING_W-1:0] h);
        logic [CARD_W:0] q;
        q = '0;
        for (int j = 1; j <= 8; j++) begin
            if (h >= HEADING_W'(4500 * j - 2250)) begin
                q = q + 1'b1;
            end
        end
        return q[CARD_W-1:0];
    endfunction

endpackage

// ===== src/calibrated_compass_heading.sv =====
// top level: calibration matrix, magnitude and heading pipeline
`timescale 1ns / 1ps

// Takes one field sample per cycle while the output is not stalled and returns one result
// word per sample, in order. A sample passes through registers for offset, matrix
// products, rounding, squaring and sum of squares, then one stage per root digit and
// per CORDIC rotation running side by side, then registers for angle wrap, rounding
// and sector lookup, the last being the output register. The whole pipeline advances
// together and holds while a result waits; configuration writes are accepted at any
// time.
module calibrated_compass_heading
    import cch_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 20,
    parameter int CORDIC_STAGES = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // field_x, field_y, field_z
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // sample_valid
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // cal_x, cal_y, cal_z, magnitude, heading, cardinal
    output logic [((4*SAMPLE_WIDTH+19+7)/8)*8-1:0] m_tdata,
    // result_valid
    output logic [0:0] m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int HW  = SW + 1;
    localparam int PW  = HW + COEF_W;
    localparam int AW  = PW + 2;
    localparam int SQW = 2 * SW;
    localparam int N   = 2 * SW + 2;
    localparam int R   = SW + 1;
    localparam int RW  = R + 2;
    localparam int CW  = SW + 20;
    localparam int D   = (R > CORDIC_STAGES) ? R : CORDIC_STAGES;
    localparam int MTW = ((4*SAMPLE_WIDTH+19+7)/8)*8;

    typedef struct packed {
        logic                    sv;
        logic                    zero;
        logic signed [SW-1:0]    cal_x;
        logic signed [SW-1:0]    cal_y;
        logic signed [SW-1:0]    cal_z;
        logic [N-1:0]            n;
        logic [RW-1:0]           rem;
        logic [R-1:0]            root;
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANGLE_W-1:0] z;
    } iter_t;

    // configuration
    logic [OFFS_REG_W-1:0] hard_reg;
    logic [ROW_REG_W-1:0]  row_reg [3];
    logic [DECL_W-1:0]     decl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hard_reg   <= '0;
            row_reg[0] <= ROW_X_RESET;
            row_reg[1] <= ROW_Y_RESET;
            row_reg[2] <= ROW_Z_RESET;
            decl_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_HARD_IRON:   hard_reg   <= cfg_data[OFFS_REG_W-1:0];
                CFG_ROW_X:       row_reg[0] <= cfg_data[ROW_REG_W-1:0];
                CFG_ROW_Y:       row_reg[1] <= cfg_data[ROW_REG_W-1:0];
                CFG_ROW_Z:       row_reg[2] <= cfg_data[ROW_REG_W-1:0];
                CFG_DECLINATION: decl_reg   <= cfg_data[DECL_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_v_reg;
    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;

    // offsets
    logic [63:0] offs_ext;
    logic signed [SW-1:0] offs [3];
    assign offs_ext = {{(64-OFFS_REG_W){1'b0}}, hard_reg};

    for (genvar k = 0; k < 3; k++) begin : g_off
        localparam int SH = k * SW;
        if (SH < 64) begin : g_in
            logic [63:0] sh_v;
            assign sh_v    = offs_ext >> SH;
            assign offs[k] = signed'(sh_v[SW-1:0]);
        end else begin : g_out
            assign offs[k] = '0;
        end
    end

    // stage 1: remove hard iron
    logic                 v1_reg, sv1_reg;
    logic signed [SW-1:0] raw1_reg [3];
    logic signed [HW-1:0] h1_reg [3];
    logic signed [SW-1:0] fin [3];
    assign fin[0] = signed'(s_tdata[SW-1:0]);
    assign fin[1] = signed'(s_tdata[2*SW-1:SW]);
    assign fin[2] = signed'(s_tdata[3*SW-1:2*SW]);

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sv1_reg <= s_tuser[0];
            for (int c = 0; c < 3; c++) begin
                raw1_reg[c] <= fin[c];
                h1_reg[c]   <= HW'(fin[c]) - HW'(offs[c]);
            end
        end
    end

    // stage 2: matrix products
    logic                 v2_reg, sv2_reg;
    logic signed [SW-1:0] raw2_reg [3];
    logic signed [PW-1:0] prod_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sv2_reg  <= sv1_reg;
            raw2_reg <= raw1_reg;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= PW'(signed'(row_reg[r][COEF_W*c +: COEF_W]))
                                    * PW'(h1_reg[c]);
                end
            end
        end
    end

    // stage 3: sum, round, saturate
    logic                 v3_reg, sv3_reg;
    logic signed [SW-1:0] cal3_reg [3];
    logic signed [SW-1:0] cal_next [3];

    always_comb begin
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] rnd;
        for (int r = 0; r < 3; r++) begin
            acc = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2]);
            rnd = (acc + AW'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (&rnd[AW-1:SW-1] || ~|rnd[AW-1:SW-1]) begin
                cal_next[r] = rnd[SW-1:0];
            end else if (rnd[AW-1]) begin
                cal_next[r] = {1'b1, {(SW-1){1'b0}}};
            end else begin
                cal_next[r] = {1'b0, {(SW-1){1'b1}}};
            end
            if (!sv2_reg) cal_next[r] = raw2_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sv3_reg  <= sv2_reg;
            cal3_reg <= cal_next;
        end
    end

    // stage 4: squares
    logic                  v4_reg, sv4_reg;
    logic signed [SW-1:0]  cal4_reg [3];
    logic signed [SQW-1:0] sq4_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sv4_reg  <= sv3_reg;
            cal4_reg <= cal3_reg;
            for (int c = 0; c < 3; c++) begin
                sq4_reg[c] <= SQW'(cal3_reg[c]) * SQW'(cal3_reg[c]);
            end
        end
    end

    // stage 5: sum of squares and cordic start
    logic  it_v_reg [D+1];
    iter_t it_reg   [D+1];
    iter_t it_init;

    always_comb begin
        logic signed [CW-1:0] x0, y0;
        x0 = CW'(cal4_reg[0]) <<< 16;
        y0 = CW'(cal4_reg[1]) <<< 16;
        it_init       = '0;
        it_init.sv    = sv4_reg;
        it_init.cal_x = cal4_reg[0];
        it_init.cal_y = cal4_reg[1];
        it_init.cal_z = cal4_reg[2];
        it_init.zero  = (cal4_reg[0] == '0) && (cal4_reg[1] == '0);
        it_init.n     = {2'b00, unsigned'(sq4_reg[0])} + {2'b00, unsigned'(sq4_reg[1])}
                      + {2'b00, unsigned'(sq4_reg[2])};
        if (x0 < 0) begin
            it_init.x = -x0;
            it_init.y = -y0;
            it_init.z = HALF_TURN;
        end else begin
            it_init.x = x0;
            it_init.y = y0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) it_v_reg[0] <= 1'b0;
        else if (adv) it_v_reg[0] <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) it_reg[0] <= it_init;
    end

    // root digits and cordic rotations, one per stage
    for (genvar k = 0; k < D; k++) begin : g_it
        iter_t nx;
        always_comb begin
            logic [RW-1:0] rem_s, trial;
            logic signed [CW-1:0] dx, dy;
            logic signed [ANGLE_W-1:0] ang;
            nx    = it_reg[k];
            rem_s = {it_reg[k].rem[RW-3:0], it_reg[k].n[N-1 -: 2]};
            trial = {it_reg[k].root, 2'b01};
            dx    = it_reg[k].y >>> k;
            dy    = it_reg[k].x >>> k;
            ang   = ANGLE_W'(ARC_TABLE[k % ARC_LEN]);
            if (k < R) begin
                nx.n = it_reg[k].n << 2;
                if (rem_s >= trial) begin
                    nx.rem  = rem_s - trial;
                    nx.root = {it_reg[k].root[R-2:0], 1'b1};
                end else begin
                    nx.rem  = rem_s;
                    nx.root = {it_reg[k].root[R-2:0], 1'b0};
                end
            end
            if (k < CORDIC_STAGES) begin
                if (!it_reg[k].y[CW-1]) begin
                    nx.x = it_reg[k].x + dx;
                    nx.y = it_reg[k].y - dy;
                    nx.z = it_reg[k].z + ang;
                end else begin
                    nx.x = it_reg[k].x - dx;
                    nx.y = it_reg[k].y + dy;
                    nx.z = it_reg[k].z - ang;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) it_v_reg[k+1] <= 1'b0;
            else if (adv) it_v_reg[k+1] <= it_v_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (adv) it_reg[k+1] <= nx;
        end
    end

    // post 1: magnitude saturation, declination and wrap
    logic                 p1_v_reg, p1_sv_reg;
    logic signed [SW-1:0] p1_cal_reg [3];
    logic [SW-1:0]        p1_mag_reg;
    logic [TURN_W-2:0]    p1_r_reg;
    logic [TURN_W-2:0]    r_next;

    always_comb begin
        logic signed [TURN_W-1:0] t, cand;
        t = it_reg[D].zero ? '0 : TURN_W'(it_reg[D].z);
        t = t + (TURN_W'(signed'(decl_reg)) <<< ANGLE_SUB_LOG);
        r_next = '0;
        for (int j = 0; j < 4; j++) begin
            cand = t + TURN_W'(j - 1) * signed'(FULL_TURN);
            if (!cand[TURN_W-1] && (cand < signed'(FULL_TURN))) begin
                r_next = cand[TURN_W-2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) p1_v_reg <= 1'b0;
        else if (adv) p1_v_reg <= it_v_reg[D];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_sv_reg     <= it_reg[D].sv;
            p1_cal_reg[0] <= it_reg[D].cal_x;
            p1_cal_reg[1] <= it_reg[D].cal_y;
            p1_cal_reg[2] <= it_reg[D].cal_z;
            p1_mag_reg    <= it_reg[D].root[R-1] ? '1 : it_reg[D].root[SW-1:0];
            p1_r_reg      <= r_next;
        end
    end

    // post 2: round to hundredths
    logic                 p2_v_reg, p2_sv_reg;
    logic signed [SW-1:0] p2_cal_reg [3];
    logic [SW-1:0]        p2_mag_reg;
    logic [HEADING_W-1:0] p2_h_reg;
    logic [TURN_W-1:0]    hsum;
    logic [HEADING_W:0]   hr;
    assign hsum = {1'b0, p1_r_reg} + TURN_W'(1 << (ANGLE_SUB_LOG - 1));
    assign hr   = hsum[ANGLE_SUB_LOG +: HEADING_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) p2_v_reg <= 1'b0;
        else if (adv) p2_v_reg <= p1_v_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_sv_reg  <= p1_sv_reg;
            p2_cal_reg <= p1_cal_reg;
            p2_mag_reg <= p1_mag_reg;
            p2_h_reg   <= (hr >= HEADING_WRAP) ? '0 : hr[HEADING_W-1:0];
        end
    end

    // output word
    logic                 out_sv_reg;
    logic signed [SW-1:0] out_cal_reg [3];
    logic [SW-1:0]        out_mag_reg;
    logic [HEADING_W-1:0] out_h_reg;
    logic [CARD_W-1:0]    out_card_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (adv) out_v_reg <= p2_v_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_sv_reg   <= p2_sv_reg;
            out_cal_reg  <= p2_cal_reg;
            out_mag_reg  <= p2_sv_reg ? p2_mag_reg : '0;
            out_h_reg    <= p2_sv_reg ? p2_h_reg : '0;
            out_card_reg <= p2_sv_reg ? sector_of(p2_h_reg) : '0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_sv_reg;
    assign m_tdata  = MTW'({out_card_reg, out_h_reg, out_mag_reg,
                            out_cal_reg[2], out_cal_reg[1], out_cal_reg[0]});

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> (out_h_reg < HEADING_W'(36000)))
        else $error("heading out of range");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !out_sv_reg) |-> (out_mag_reg == '0 && out_card_reg == '0))
        else $error("invalid sample carries magnitude or sector");

    a_mag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && out_sv_reg && out_mag_reg == '0) |->
        (out_cal_reg[0] == '0 && out_cal_reg[1] == '0 && out_cal_reg[2] == '0))
        else $error("zero magnitude for nonzero vector");

endmodule
